### hw/rtl/bsm_pkg.sv
// Shared types, constants and helper functions for the bounding sphere merge block.
package bsm_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [30:0] RAD_ONE = 31'(64'd1 << FRAC_BITS);
    localparam logic [30:0] RAD_MAX = {31{1'b1}};

    // sequencer lengths: squared terms issued, root bits, quotient bits
    localparam int MUL_OPS    = 5;
    localparam int SQRT_STEPS = 34;
    localparam int DIV_STEPS  = 31;

    localparam logic CMD_MERGE = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    typedef enum logic [1:0] {
        OC_KEPT,
        OC_TOOK,
        OC_ENCL,
        OC_LOAD
    } t_outcome;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_SQRT,
        S_RAD,
        S_DMUL,
        S_DINIT,
        S_DIV,
        S_AXIS,
        S_FIN
    } t_state;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic [30:0]        in_radius;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [30:0]        out_radius;
        t_outcome           outcome;
        logic               overlapped;
    } t_out_item;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // magnitude of a radius difference, always below 2^31
    function automatic logic [30:0] mag32(input logic signed [31:0] v);
        logic signed [31:0] n;
        n = -v;
        return v[31] ? n[30:0] : v[30:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/bsm_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface bsm_in_if;
    logic              valid;
    logic              ready;
    bsm_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bsm_out_if;
    logic               valid;
    logic               ready;
    bsm_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/bounding_sphere_merge.sv
// Running bounding sphere in signed Q16.16: load or merge one sphere per transaction.
// One item is taken at a time; i_in.ready is high only while the sequencer is idle.
// A load, or a merge where one sphere contains the other, goes from the compare straight
// to the result. A merge that encloses both runs the squared terms through the single
// 33x33 multiplier, the compares, the bit-per-cycle square root, the radius, the scaled
// offset per axis (one multiply, then a 31-step restoring divide) and the result load.
// The sequencer then returns to idle before the next accept. The root and the divides
// share one subtractor.
// A finished result sits in an output register, so the next item can be
// accepted while the previous result waits on o_out.ready.
module bounding_sphere_merge import bsm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    bsm_in_if.sink    i_in,
    bsm_out_if.source o_out
);

    t_state r_state, n_state;

    logic [5:0]         r_cnt;
    logic [1:0]         r_ax;
    logic signed [31:0] r_c [3];
    logic [30:0]        r_sr;
    logic signed [31:0] r_inc [3];
    logic [30:0]        r_ir;
    logic               r_cmd;
    logic signed [32:0] r_dax [3];
    logic signed [31:0] r_diff;
    logic [31:0]        r_sum;
    logic [65:0]        r_prod;
    logic [65:0]        r_dd;
    logic [63:0]        r_sr2;
    logic [61:0]        r_df2;
    logic [36:0]        r_rem;
    logic [33:0]        r_root;
    logic [67:0]        r_sqsrc;
    logic [30:0]        r_lo;
    t_outcome           r_oc;
    logic               r_ovl;
    logic               r_ov;
    t_out_item          r_out;

    logic               accept;
    logic [30:0]        ir_fix;
    logic [32:0]        mul_a, mul_b;
    logic [65:0]        prod;
    logic [36:0]        sq_cand;
    logic [34:0]        dv_cand;
    logic [36:0]        sub_a, sub_b;
    logic [37:0]        sub_w;
    logic               sub_ge;
    logic               contained;
    logic [34:0]        rad_sum;
    logic [30:0]        rad_sat;
    logic               t_neg;
    logic signed [33:0] tval;
    logic signed [33:0] ax_sum;
    logic signed [31:0] ax_new;
    logic               out_load;

    assign accept = i_in.valid && i_in.ready;
    assign ir_fix = (i_in.payload.in_radius == '0) ? 31'd1 : i_in.payload.in_radius;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL: begin
                case (r_cnt)
                    6'd0: begin
                        mul_a = mag33(r_dax[0]);
                        mul_b = mag33(r_dax[0]);
                    end
                    6'd1: begin
                        mul_a = mag33(r_dax[1]);
                        mul_b = mag33(r_dax[1]);
                    end
                    6'd2: begin
                        mul_a = mag33(r_dax[2]);
                        mul_b = mag33(r_dax[2]);
                    end
                    6'd3: begin
                        mul_a = {1'b0, r_sum};
                        mul_b = {1'b0, r_sum};
                    end
                    6'd4: begin
                        mul_a = {2'b0, mag32(r_diff)};
                        mul_b = {2'b0, mag32(r_diff)};
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_DMUL: begin
                mul_a = {2'b0, mag32(r_diff)};
                mul_b = mag33(r_dax[r_ax]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // shared compare/subtract for the root and the divides
    assign sq_cand = {r_rem[34:0], r_sqsrc[67:66]};
    assign dv_cand = {r_rem[33:0], r_lo[30]};

    always_comb begin
        case (r_state)
            S_SQRT: begin
                sub_a = sq_cand;
                sub_b = {1'b0, r_root, 2'b01};
            end
            S_DIV: begin
                sub_a = {2'b0, dv_cand};
                sub_b = {3'b0, r_root};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_w  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_w[37];

    assign contained = ({4'b0, r_df2} >= r_dd);

    assign rad_sum = 35'(r_sum) + 35'(r_root);
    assign rad_sat = (rad_sum[34:32] != '0) ? RAD_MAX : rad_sum[31:1];

    // center axis: floor((c0 + c1 + t) / 2), t signed by diff and axis offset
    assign t_neg  = r_diff[31] ^ r_dax[r_ax][32];
    assign tval   = t_neg ? -$signed({3'b0, r_lo}) : $signed({3'b0, r_lo});
    assign ax_sum = 34'(r_c[r_ax]) + 34'(r_inc[r_ax]) + tval;
    assign ax_new = sat32(ax_sum[33:1]);

    assign out_load = (r_state == S_FIN) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == 6'(MUL_OPS)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_cmd == CMD_LOAD || contained) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                    n_state = S_RAD;
                end
            end
            S_RAD:   n_state = S_DMUL;
            S_DMUL:  n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = S_AXIS;
                end
            end
            S_AXIS: begin
                if (r_ax == 2'd2) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DMUL;
                end
            end
            S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (!i_rst_n) begin
            r_c[0] <= '0;
            r_c[1] <= '0;
            r_c[2] <= '0;
            r_sr   <= RAD_ONE;
            r_ov   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_in.payload.cmd;
                        r_ir     <= ir_fix;
                        r_inc[0] <= i_in.payload.in_x;
                        r_inc[1] <= i_in.payload.in_y;
                        r_inc[2] <= i_in.payload.in_z;
                        r_dax[0] <= 33'(i_in.payload.in_x) - 33'(r_c[0]);
                        r_dax[1] <= 33'(i_in.payload.in_y) - 33'(r_c[1]);
                        r_dax[2] <= 33'(i_in.payload.in_z) - 33'(r_c[2]);
                        r_diff   <= $signed({1'b0, ir_fix}) - $signed({1'b0, r_sr});
                        r_sum    <= 32'(ir_fix) + 32'(r_sr);
                        r_dd     <= '0;
                        r_cnt    <= '0;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 6'd1;
                    // product of the previous issue lands here
                    case (r_cnt)
                        6'd1, 6'd2, 6'd3: r_dd <= r_dd + r_prod;
                        6'd4: r_sr2 <= r_prod[63:0];
                        6'd5: r_df2 <= r_prod[61:0];
                        default: r_dd <= r_dd;
                    endcase
                end
                S_CMP: begin
                    r_ovl <= (r_dd < {2'b0, r_sr2});
                    if (r_cmd == CMD_LOAD) begin
                        r_c  <= r_inc;
                        r_sr <= r_ir;
                        r_oc <= OC_LOAD;
                    end else if (contained) begin
                        if (!r_diff[31] && r_diff != '0) begin
                            r_c  <= r_inc;
                            r_sr <= r_ir;
                            r_oc <= OC_TOOK;
                        end else begin
                            r_oc <= OC_KEPT;
                        end
                    end else begin
                        r_oc    <= OC_ENCL;
                        r_sqsrc <= {2'b0, r_dd};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                    end
                end
                S_SQRT: begin
                    r_cnt   <= r_cnt + 6'd1;
                    r_sqsrc <= {r_sqsrc[65:0], 2'b00};
                    if (sub_ge) begin
                        r_rem  <= sub_w[36:0];
                        r_root <= {r_root[32:0], 1'b1};
                    end else begin
                        r_rem  <= sq_cand;
                        r_root <= {r_root[32:0], 1'b0};
                    end
                end
                S_RAD: begin
                    r_sr <= rad_sat;
                    r_ax <= '0;
                end
                S_DINIT: begin
                    // quotient is known to fit 31 bits, so start 31 bits down
                    r_rem <= 37'(r_prod[63:31]);
                    r_lo  <= r_prod[30:0];
                    r_cnt <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    r_lo  <= {r_lo[29:0], sub_ge};
                    if (sub_ge) begin
                        r_rem <= sub_w[36:0];
                    end else begin
                        r_rem <= 37'(dv_cand);
                    end
                end
                S_AXIS: begin
                    r_c[r_ax] <= ax_new;
                    r_ax      <= r_ax + 2'd1;
                end
                default: r_cnt <= r_cnt;
            endcase

            if (out_load) begin
                r_ov <= 1'b1;
                r_out <= '{
                    out_x:      r_c[0],
                    out_y:      r_c[1],
                    out_z:      r_c[2],
                    out_radius: r_sr,
                    outcome:    r_oc,
                    overlapped: r_ovl
                };
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.payload = r_out;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("input accepted while a transaction is in progress");

    a_root_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RAD) |-> (r_rem <= {2'b0, r_root, 1'b0}))
        else $error("square root remainder out of range");

    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AXIS) |-> (r_lo <= mag32(r_diff)))
        else $error("axis offset exceeds radius difference");

    a_radius_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.payload.out_radius != '0))
        else $error("result radius is zero");
`endif

endmodule

### bench/tb_top.sv
// Self-checking bench for bounding_sphere_merge: directed table, then random load/merge traffic.
`timescale 1ns / 100ps

module tb_top;
    import bsm_pkg::*;

    localparam int     RANDOM_ITEMS = 1750;
    localparam int     CYCLE_LIMIT  = 1200000;
    localparam int     DRAIN_CYCLES = 200;
    localparam int     PRINT_LIMIT  = 100;
    localparam longint AXIS_MAX     = 64'sh7FFF_FFFF;
    localparam longint AXIS_MIN     = -64'sh8000_0000;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    bsm_in_if  in_bus ();
    bsm_out_if out_bus ();

    bounding_sphere_merge u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // sphere held by the predictor
    logic signed [31:0] held_x;
    logic signed [31:0] held_y;
    logic signed [31:0] held_z;
    logic [30:0]        held_r;

    t_out_item pending_spheres[$];
    t_row      rows[$];
    int        err_count   = 0;
    int        cycle_count = 0;
    int        rx_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch on result %0d: %s", $realtime, rx_count, msg);
        end
        err_count++;
    endtask

    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [33:0] root_floor(input logic [67:0] v);
        logic [33:0] res;
        logic [33:0] c;
        res = '0;
        for (int b = 33; b >= 0; b--) begin
            c = res | (34'd1 << b);
            if (68'(c) * 68'(c) <= v) begin
                res = c;
            end
        end
        return res;
    endfunction

    // center axis: floor((c0 + c1 + (r1 - r0) * D_axis / d) / 2), saturated to 32 bits
    function automatic logic signed [31:0] shift_axis(input logic signed [31:0] c0,
            input logic signed [31:0] c1, input longint diff, input logic [33:0] d);
        longint      dax;
        longint      t;
        longint      s;
        logic [63:0] q;
        dax = longint'(c1) - longint'(c0);
        q   = (mag64(diff) * mag64(dax)) / 64'(d);
        t   = ((diff < 0) != (dax < 0)) ? -longint'(q) : longint'(q);
        s   = (longint'(c0) + longint'(c1) + t) >>> 1;
        if (s > AXIS_MAX) begin
            s = AXIS_MAX;
        end else if (s < AXIS_MIN) begin
            s = AXIS_MIN;
        end
        return 32'(s);
    endfunction

    // applies one transaction to the held sphere and returns the result it produces
    function automatic t_out_item fold_sphere(input t_in_item it);
        t_out_item          res;
        logic [30:0]        ir;
        longint             dx, dy, dz, diff;
        logic [67:0]        dd, sr, sr2, gap2;
        logic [33:0]        d;
        logic [34:0]        r;
        logic signed [31:0] nx, ny, nz;
        ir   = (it.in_radius == '0) ? 31'd1 : it.in_radius;
        dx   = longint'(it.in_x) - longint'(held_x);
        dy   = longint'(it.in_y) - longint'(held_y);
        dz   = longint'(it.in_z) - longint'(held_z);
        dd   = 68'(mag64(dx)) * 68'(mag64(dx)) + 68'(mag64(dy)) * 68'(mag64(dy))
             + 68'(mag64(dz)) * 68'(mag64(dz));
        sr   = 68'(ir) + 68'(held_r);
        sr2  = sr * sr;
        res.overlapped = (dd < sr2);
        diff = longint'(ir) - longint'(held_r);
        gap2 = 68'(mag64(diff)) * 68'(mag64(diff));
        if (it.cmd == CMD_LOAD) begin
            held_x = it.in_x;
            held_y = it.in_y;
            held_z = it.in_z;
            held_r = ir;
            res.outcome = OC_LOAD;
        end else if (gap2 >= dd) begin
            // one sphere contains the other; ties keep the stored one
            if (diff > 0) begin
                held_x = it.in_x;
                held_y = it.in_y;
                held_z = it.in_z;
                held_r = ir;
                res.outcome = OC_TOOK;
            end else begin
                res.outcome = OC_KEPT;
            end
        end else begin
            d = root_floor(dd);
            r = (35'(held_r) + 35'(d) + 35'(ir)) >> 1;
            if (d == '0) begin
                d = 34'd1;
            end
            nx = shift_axis(held_x, it.in_x, diff, d);
            ny = shift_axis(held_y, it.in_y, diff, d);
            nz = shift_axis(held_z, it.in_z, diff, d);
            held_x = nx;
            held_y = ny;
            held_z = nz;
            held_r = (r > 35'(RAD_MAX)) ? RAD_MAX : r[30:0];
            res.outcome = OC_ENCL;
        end
        res.out_x      = held_x;
        res.out_y      = held_y;
        res.out_z      = held_z;
        res.out_radius = held_r;
        return res;
    endfunction

    // stretches with random waits alternate with full-rate stretches (one span in four)
    function automatic int draw_wait(input int n, input int span);
        return ((n / span) % 4 == 3) ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] near);
        longint v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = AXIS_MAX;
                    1: v = AXIS_MIN;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            1, 2, 3: v = longint'($signed(32'($urandom)));
            4, 5, 6: v = longint'($urandom_range(0, 2097152)) - 1048576;
            default: begin
                v = longint'(near) + longint'($urandom_range(0, 524288)) - 262144;
                if (v > AXIS_MAX) begin
                    v = AXIS_MAX;
                end else if (v < AXIS_MIN) begin
                    v = AXIS_MIN;
                end
            end
        endcase
        return 32'(v);
    endfunction

    task automatic add_row(input logic cmd, input int x, input int y, input int z,
            input int unsigned rad, input bit typed, input int ex, input int ey,
            input int ez, input int unsigned er, input t_outcome oc, input bit ov);
        t_row row;
        row.item.cmd       = cmd;
        row.item.in_x      = x;
        row.item.in_y      = y;
        row.item.in_z      = z;
        row.item.in_radius = rad[30:0];
        row.typed          = typed;
        row.want.out_x      = ex;
        row.want.out_y      = ey;
        row.want.out_z      = ez;
        row.want.out_radius = er[30:0];
        row.want.outcome    = oc;
        row.want.overlapped = ov;
        rows.insert(rows.size(), row);
    endtask

    // drives one transaction and queues its expected result once accepted
    task automatic send_sphere(input t_in_item it, input bit typed, input t_out_item want,
            input int n);
        t_out_item pred;
        int        gap;
        gap = draw_wait(n, 100);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.payload <= it;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        pred = fold_sphere(it);
        pending_spheres.insert(pending_spheres.size(), typed ? want : pred);
    endtask

    initial begin
        t_in_item  it;
        t_out_item blank;
        longint    rv;
        blank = '0;
        i_rst_n        <= 1'b0;
        in_bus.valid   <= 1'b0;
        in_bus.payload <= '0;
        held_x = '0;
        held_y = '0;
        held_z = '0;
        held_r = RAD_ONE;

        // containment against the reset unit sphere
        add_row(CMD_MERGE, 0, 0, 0, 32'h8000, 1, 0, 0, 0, 32'h10000, OC_KEPT, 1);
        add_row(CMD_MERGE, 0, 0, 0, 32'h10000, 1, 0, 0, 0, 32'h10000, OC_KEPT, 1);
        // zero radius counts as one LSB
        add_row(CMD_MERGE, 0, 0, 0, 0, 1, 0, 0, 0, 32'h10000, OC_KEPT, 1);
        add_row(CMD_MERGE, 0, 0, 0, 32'h20000, 1, 0, 0, 0, 32'h20000, OC_TOOK, 1);
        // loads at the extremes, far apart
        add_row(CMD_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, OC_LOAD, 0);
        add_row(CMD_LOAD, 32'h80000000, 32'h80000000, 32'h80000000, 1, 1,
                32'h80000000, 32'h80000000, 32'h80000000, 1, OC_LOAD, 0);
        // enclosing merges that saturate
        add_row(CMD_MERGE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0,
                0, 0, 0, 0, OC_KEPT, 0);
        add_row(CMD_MERGE, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0,
                0, 0, 0, 0, OC_KEPT, 0);
        add_row(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, OC_KEPT, 0);
        add_row(CMD_LOAD, 0, 0, 0, 32'h10000, 1, 0, 0, 0, 32'h10000, OC_LOAD, 1);
        // spheres that only touch: no strict overlap
        add_row(CMD_MERGE, 32'h20000, 0, 0, 32'h10000, 1,
                32'h10000, 0, 0, 32'h20000, OC_ENCL, 0);
        // containment ties, both directions
        add_row(CMD_MERGE, 0, 0, 0, 32'h10000, 1, 32'h10000, 0, 0, 32'h20000, OC_KEPT, 1);
        add_row(CMD_MERGE, 32'h20000, 0, 0, 32'h30000, 1,
                32'h20000, 0, 0, 32'h30000, OC_TOOK, 1);
        add_row(CMD_MERGE, -32'sh30000, 32'h18000, -32'sh8000, 32'h14000, 0,
                0, 0, 0, 0, OC_KEPT, 0);
        add_row(CMD_MERGE, 32'h7FFF0000, -32'sh40000000, 32'h1234, 32'h100, 0,
                0, 0, 0, 0, OC_KEPT, 0);
        add_row(CMD_LOAD, -1, -1, -1, 32'h7FFFFFFF, 0, 0, 0, 0, 0, OC_KEPT, 0);
        add_row(CMD_MERGE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0,
                0, 0, 0, 0, OC_KEPT, 0);
        add_row(CMD_LOAD, 32'h40000000, 0, 0, 32'h10000, 0, 0, 0, 0, 0, OC_KEPT, 0);
        add_row(CMD_MERGE, -32'sh40000000, 0, 0, 32'h10000, 0, 0, 0, 0, 0, OC_KEPT, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_sphere(rows[i].item, rows[i].typed, rows[i].want, i);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it.cmd  = ($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_MERGE;
            it.in_x = pick_coord(held_x);
            it.in_y = pick_coord(held_y);
            it.in_z = pick_coord(held_z);
            // radius near the held one makes containment and ties likely
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 2))
                        0: rv = 0;
                        1: rv = 1;
                        default: rv = longint'(RAD_MAX);
                    endcase
                end
                1, 2: rv = longint'($urandom_range(0, 32'h7FFFFFFF));
                3, 4, 5: rv = longint'($urandom_range(1, 1048576));
                default: begin
                    rv = longint'(held_r) + longint'($urandom_range(0, 262144)) - 131072;
                    if (rv < 0) begin
                        rv = 0;
                    end else if (rv > longint'(RAD_MAX)) begin
                        rv = longint'(RAD_MAX);
                    end
                end
            endcase
            it.in_radius = 31'(rv);
            send_sphere(it, 1'b0, blank, n + rows.size());
        end
        in_bus.valid <= 1'b0;

        while (pending_spheres.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        t_out_item got;
        t_out_item want;
        int        stall;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(rx_count, 70);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_bus.valid) @(posedge i_clk);
            got = out_bus.payload;
            if (pending_spheres.size() == 0) begin
                flag_mismatch("result with no transaction pending");
            end else begin
                want = pending_spheres.pop_front();
                if (got.out_x !== want.out_x)
                    flag_mismatch($sformatf("x %h, want %h", got.out_x, want.out_x));
                if (got.out_y !== want.out_y)
                    flag_mismatch($sformatf("y %h, want %h", got.out_y, want.out_y));
                if (got.out_z !== want.out_z)
                    flag_mismatch($sformatf("z %h, want %h", got.out_z, want.out_z));
                if (got.out_radius !== want.out_radius)
                    flag_mismatch($sformatf("radius %h, want %h", got.out_radius,
                                            want.out_radius));
                if (got.outcome !== want.outcome)
                    flag_mismatch($sformatf("outcome %0d, want %0d", got.outcome,
                                            want.outcome));
                if (got.overlapped !== want.overlapped)
                    flag_mismatch($sformatf("overlapped %b, want %b", got.overlapped,
                                            want.overlapped));
            end
            rx_count++;
        end
    end

endmodule
